>>> sv/mmfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator package
// Shared constants, field types, operation codes and controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package mmfa_pkg;

	localparam int ADDR_BITS  = 48;
	localparam int PAGE_SHIFT = 12;
	localparam int PIDX_W     = ADDR_BITS - PAGE_SHIFT;
	localparam int FRAME_W    = 37;
	localparam int RCNT_W     = 5;
	localparam int CIDX_W     = 3;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [PIDX_W-1:0]    pidx_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_A2F   = 2'd1,
		OP_F2A   = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_KERNEL_LO    = 3'd0,
		CFG_KERNEL_HI    = 3'd1,
		CFG_BOOTINFO_LO  = 3'd2,
		CFG_BOOTINFO_HI  = 3'd3,
		CFG_REGION_COUNT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MSEL_K = 2'd0,
		MSEL_L = 2'd1,
		MSEL_H = 2'd2
	} msel_t;

	typedef struct packed {
		addr_t base;
		addr_t len;
		logic  avail;
	} rgn_t;

	typedef struct packed {
		pidx_t a;
		pidx_t b;
	} span_t;

	typedef struct packed {
		logic  start;
		logic  load;
		logic  rd;
		logic  geom;
		logic  span;
		logic  cnt;
		msel_t msel;
		logic  sum;
		logic  hit_l;
		logic  hit_h;
		logic  chk;
		logic  sort;
		logic  merge;
		logic  walk1;
		logic  walk2;
		logic  addr;
		logic  adv;
		logic  fin;
		logic  found;
	} cmd_t;

	typedef struct packed {
		logic rgn_end;
		logic skip;
		logic mode_a2f;
		logic qge;
		logic hit_l;
		logic hit_h;
		logic in_range;
	} sts_t;

endpackage

>>> sv/mmfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmfa_in_if import mmfa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           operation;
	logic [3:0]           entry_index;
	logic [ADDR_BITS-1:0] entry_base;
	logic [ADDR_BITS-1:0] entry_length;
	logic                 entry_is_available;
	logic [ADDR_BITS-1:0] query_value;

	modport source(output valid, operation, entry_index, entry_base, entry_length,
		entry_is_available, query_value, input ready);
	modport sink(input valid, operation, entry_index, entry_base, entry_length,
		entry_is_available, query_value, output ready);
endinterface

interface mmfa_out_if import mmfa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] answer;
	logic                 alloc_failed;

	modport source(output valid, answer, alloc_failed, input ready);
	modport sink(input valid, answer, alloc_failed, output ready);
endinterface

>>> sv/memory_map_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory map frame allocator
// Bump frame allocator over a table of physical memory regions.
// ----------------------------------------------------------------------------
// A load item is written while idle. A query is accepted, then walks the
// region table one entry per pass through a shared datapath: a skipped region
// is read, sized and passed over; a counted one adds span and count steps.
// A frame-to-address hit then walks the reserved spans to form its address.
// The result waits out receiver stalls. One item is in flight at a time.
// Reset clears the configuration registers and sets the frame counter to 1;
// region table entries hold nothing until loaded.
// ----------------------------------------------------------------------------
module memory_map_frame_allocator import mmfa_pkg::*; #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CIDX_W-1:0]    cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data,
	mmfa_in_if.sink              request,
	mmfa_out_if.source           response
);

	cmd_t cmd;
	sts_t sts;

	mmfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_is_load (op_t'(request.operation) == OP_LOAD),
		.in_ready   (request.ready),
		.out_valid  (response.valid),
		.out_ready  (response.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mmfa_datapath #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.operation          (request.operation),
		.entry_index        (request.entry_index),
		.entry_base         (request.entry_base),
		.entry_length       (request.entry_length),
		.entry_is_available (request.entry_is_available),
		.query_value        (request.query_value),
		.cmd                (cmd),
		.sts                (sts),
		.answer             (response.answer),
		.alloc_failed       (response.alloc_failed)
	);

endmodule

>>> sv/mmfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator controller
// Sequences the region walk, one table entry per pass, and the handshake.
// ----------------------------------------------------------------------------
module mmfa_ctrl import mmfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_is_load,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_RD    = 20'h00002,
		ST_GEOM  = 20'h00004,
		ST_SPAN  = 20'h00008,
		ST_CNTK  = 20'h00010,
		ST_SUMK  = 20'h00020,
		ST_CNTL  = 20'h00040,
		ST_HITL  = 20'h00080,
		ST_CNTH  = 20'h00100,
		ST_HITH  = 20'h00200,
		ST_CHK   = 20'h00400,
		ST_SORT  = 20'h00800,
		ST_MERGE = 20'h01000,
		ST_WALK1 = 20'h02000,
		ST_WALK2 = 20'h04000,
		ST_ADDR  = 20'h08000,
		ST_ADV   = 20'h10000,
		ST_FOUND = 20'h20000,
		ST_NONE  = 20'h40000,
		ST_OUT   = 20'h80000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_is_load) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_RD;
					end
				end
			end
			ST_RD: begin
				if (sts.rgn_end) begin
					state_d = ST_NONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_GEOM;
				end
			end
			ST_GEOM: begin
				cmd.geom = 1'b1;
				state_d  = sts.skip ? ST_ADV : ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span = 1'b1;
				state_d  = ST_CNTK;
			end
			ST_CNTK: begin
				cmd.cnt  = 1'b1;
				cmd.msel = MSEL_K;
				state_d  = ST_SUMK;
			end
			ST_SUMK: begin
				cmd.sum = 1'b1;
				if (sts.mode_a2f) begin
					state_d = sts.qge ? ST_CNTL : ST_ADV;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CNTL: begin
				cmd.cnt  = 1'b1;
				cmd.msel = MSEL_L;
				state_d  = ST_HITL;
			end
			ST_HITL: begin
				cmd.hit_l = 1'b1;
				state_d   = sts.hit_l ? ST_FOUND : ST_CNTH;
			end
			ST_CNTH: begin
				cmd.cnt  = 1'b1;
				cmd.msel = MSEL_H;
				state_d  = ST_HITH;
			end
			ST_HITH: begin
				cmd.hit_h = 1'b1;
				state_d   = sts.hit_h ? ST_FOUND : ST_ADV;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = sts.in_range ? ST_SORT : ST_ADV;
			end
			ST_SORT: begin
				cmd.sort = 1'b1;
				state_d  = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = ST_WALK1;
			end
			ST_WALK1: begin
				cmd.walk1 = 1'b1;
				state_d   = ST_WALK2;
			end
			ST_WALK2: begin
				cmd.walk2 = 1'b1;
				state_d   = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_FOUND;
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = ST_RD;
			end
			ST_FOUND: begin
				cmd.fin   = 1'b1;
				cmd.found = 1'b1;
				state_d   = ST_OUT;
			end
			ST_NONE: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/mmfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator datapath
// Region table, configuration registers, frame counter and the per-region
// page counting arithmetic.
// ----------------------------------------------------------------------------
module mmfa_datapath import mmfa_pkg::*; #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CIDX_W-1:0]    cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  logic [1:0]           operation,
	input  logic [3:0]           entry_index,
	input  logic [ADDR_BITS-1:0] entry_base,
	input  logic [ADDR_BITS-1:0] entry_length,
	input  logic                 entry_is_available,
	input  logic [ADDR_BITS-1:0] query_value,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [ADDR_BITS-1:0] answer,
	output logic                 alloc_failed
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int RW = $clog2(MAX_REGIONS + 1);

	function automatic span_t res_span(addr_t base, addr_t lo, addr_t hi, pidx_t n);
		addr_t         dl;
		addr_t         dh;
		logic [PIDX_W:0] a;
		logic [PIDX_W:0] b;
		span_t         s;
		dl = lo - base;
		dh = hi - base;
		a  = (lo > base) ? ({1'b0, dl[ADDR_BITS-1:PAGE_SHIFT]}
			+ (PIDX_W+1)'(|dl[PAGE_SHIFT-1:0])) : '0;
		b  = {1'b0, dh[ADDR_BITS-1:PAGE_SHIFT]} + (PIDX_W+1)'(1);
		if (a > {1'b0, n}) a = {1'b0, n};
		if (b > {1'b0, n}) b = {1'b0, n};
		if (a > b) a = b;
		s.a = a[PIDX_W-1:0];
		s.b = b[PIDX_W-1:0];
		if (lo > hi || hi < base) s = '0;
		return s;
	endfunction

	function automatic pidx_t cnt(pidx_t a, pidx_t b, pidx_t m);
		pidx_t e;
		e = (b < m) ? b : m;
		return (e > a) ? (e - a) : '0;
	endfunction

	function automatic logic usable(span_t x, span_t y, pidx_t k);
		return !(k >= x.a && k < x.b) && !(k >= y.a && k < y.b);
	endfunction

	// Configuration and allocation counter.
	addr_t              klo_q, khi_q, blo_q, bhi_q;
	logic [RCNT_W-1:0]  rcnt_q;
	logic [FRAME_W-1:0] next_frame_q;

	// Region table.
	rgn_t region_mem [MAX_REGIONS];
	rgn_t rd_q;

	// Walk state.
	op_t          op_q;
	addr_t        req_q, cur_q, d_q, j_q, ans_q, answer_q;
	logic         qge_q, fail_q;
	logic [RW-1:0] r_q;
	pidx_t        k_q, kl_q, kh_q, m_q, c1_q, c2_q, c3_q, u_q, kw_q;
	span_t        x_q, y_q, i1_q, i2_q;

	pidx_t        k_len, k_top, k_geom, kh_c, m_c, ub, jp;
	addr_t        lenm1, top_room, j_c;
	logic         load_ok;
	logic [IW-1:0] widx;

	assign lenm1    = rd_q.len - ADDR_BITS'(1);
	assign top_room = ~rd_q.base;
	assign k_len    = lenm1[ADDR_BITS-1:PAGE_SHIFT];
	assign k_top    = top_room[ADDR_BITS-1:PAGE_SHIFT];
	assign k_geom   = (k_len < k_top) ? k_len : k_top;
	assign kh_c     = d_q[ADDR_BITS-1:PAGE_SHIFT];
	assign ub       = m_q - c1_q - c2_q + c3_q;
	assign j_c      = req_q - cur_q;
	assign jp       = j_q[PIDX_W-1:0];
	assign load_ok  = cmd.load && (int'(entry_index) < MAX_REGIONS);
	assign widx     = IW'(entry_index);

	always_comb begin
		case (cmd.msel)
			MSEL_L:  m_c = kl_q;
			MSEL_H:  m_c = kh_q;
			default: m_c = k_q;
		endcase
	end

	assign sts.rgn_end  = (int'(r_q) >= int'(rcnt_q)) || (int'(r_q) >= MAX_REGIONS);
	assign sts.skip     = !rd_q.avail || (rd_q.len == '0) || (k_geom == '0);
	assign sts.mode_a2f = (op_q == OP_A2F);
	assign sts.qge      = qge_q;
	assign sts.hit_l    = (kl_q < k_q) && usable(x_q, y_q, kl_q);
	assign sts.hit_h    = (kh_q != kl_q) && (kh_q < k_q) && usable(x_q, y_q, kh_q);
	assign sts.in_range = (j_c < ADDR_BITS'(u_q));

	assign answer       = answer_q;
	assign alloc_failed = fail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klo_q        <= '0;
			khi_q        <= '0;
			blo_q        <= '0;
			bhi_q        <= '0;
			rcnt_q       <= '0;
			next_frame_q <= FRAME_W'(1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KERNEL_LO:    klo_q  <= cfg_data;
					CFG_KERNEL_HI:    khi_q  <= cfg_data;
					CFG_BOOTINFO_LO:  blo_q  <= cfg_data;
					CFG_BOOTINFO_HI:  bhi_q  <= cfg_data;
					CFG_REGION_COUNT: rcnt_q <= cfg_data[RCNT_W-1:0];
					default: ;
				endcase
			end
			// A frame is handed out only when its page address is nonzero.
			if (cmd.fin && cmd.found && op_q == OP_ALLOC && ans_q != '0) begin
				next_frame_q <= next_frame_q + FRAME_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			region_mem[widx] <= '{base: entry_base, len: entry_length,
				avail: entry_is_available};
		end
		if (cmd.rd) begin
			rd_q <= region_mem[r_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op_t'(operation);
			req_q <= (op_t'(operation) == OP_ALLOC) ? ADDR_BITS'(next_frame_q) : query_value;
			cur_q <= '0;
			r_q   <= '0;
		end
		if (cmd.geom) begin
			k_q   <= k_geom;
			d_q   <= req_q - rd_q.base;
			qge_q <= (req_q >= rd_q.base);
			u_q   <= '0;
		end
		if (cmd.span) begin
			x_q  <= res_span(rd_q.base, klo_q, khi_q, k_q);
			y_q  <= res_span(rd_q.base, blo_q, bhi_q, k_q);
			kh_q <= kh_c;
			// An address on a page boundary is tried against the page before it first.
			kl_q <= (d_q[PAGE_SHIFT-1:0] == '0 && kh_c != '0) ? kh_c - PIDX_W'(1) : kh_c;
		end
		if (cmd.cnt) begin
			m_q  <= m_c;
			c1_q <= cnt(x_q.a, x_q.b, m_c);
			c2_q <= cnt(y_q.a, y_q.b, m_c);
			c3_q <= cnt((x_q.a > y_q.a) ? x_q.a : y_q.a,
				(x_q.b < y_q.b) ? x_q.b : y_q.b, m_c);
		end
		if (cmd.sum) begin
			u_q <= ub;
		end
		if (cmd.hit_l || cmd.hit_h) begin
			ans_q <= cur_q + ADDR_BITS'(ub) + ADDR_BITS'(1);
		end
		if (cmd.chk) begin
			j_q <= j_c;
		end
		if (cmd.sort) begin
			if (x_q.a <= y_q.a) begin
				i1_q <= x_q;
				i2_q <= y_q;
			end else begin
				i1_q <= y_q;
				i2_q <= x_q;
			end
		end
		// Overlapping or adjacent reserved spans fold into the first one.
		if (cmd.merge && i1_q.a < i1_q.b && i2_q.a <= i1_q.b) begin
			i1_q.b <= (i2_q.b > i1_q.b) ? i2_q.b : i1_q.b;
			i2_q.b <= i2_q.a;
		end
		if (cmd.walk1) begin
			kw_q <= (i1_q.a <= jp) ? jp + (i1_q.b - i1_q.a) : jp;
		end
		if (cmd.walk2) begin
			kw_q <= (i2_q.a <= kw_q) ? kw_q + (i2_q.b - i2_q.a) : kw_q;
		end
		if (cmd.addr) begin
			ans_q <= rd_q.base + {kw_q, PAGE_SHIFT'(0)};
		end
		if (cmd.adv) begin
			cur_q <= cur_q + ADDR_BITS'(u_q);
			r_q   <= r_q + RW'(1);
		end
		if (cmd.fin) begin
			if (op_q == OP_ALLOC) begin
				if (cmd.found && ans_q != '0) begin
					answer_q <= ADDR_BITS'(next_frame_q);
					fail_q   <= 1'b0;
				end else begin
					answer_q <= '0;
					fail_q   <= 1'b1;
				end
			end else begin
				answer_q <= cmd.found ? ans_q : '0;
				fail_q   <= 1'b0;
			end
		end
	end

endmodule

>>> sim/memory_map_frame_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Loads region tables, sets reserved ranges and region counts, and checks
// every address, frame and allocate answer against a built-in predictor.
// ----------------------------------------------------------------------------
module memory_map_frame_allocator_tb;
	import mmfa_pkg::*;

	localparam int          TBL_DEPTH = 16;
	localparam logic [63:0] PG        = 64'd4096;
	localparam logic [63:0] AMASK     = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] FMASK     = 64'h1F_FFFF_FFFF;
	localparam int          SETTLE    = 200;

	typedef logic [63:0] u64_t;
	typedef struct {
		u64_t a;
		u64_t b;
	} page_span_t;
	typedef struct {
		op_t         op;
		logic [3:0]  idx;
		addr_t       base;
		addr_t       len;
		logic        avail;
		addr_t       query;
		logic        typed;
		addr_t       ans;
		logic        fail;
	} stim_row_t;
	typedef struct {
		addr_t ans;
		logic  fail;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	addr_t cfg_data = '0;

	mmfa_in_if  req_if();
	mmfa_out_if rsp_if();

	memory_map_frame_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (req_if),
		.response (rsp_if)
	);

	always #6 clk = ~clk;

	// Shadow of the block's state.
	u64_t tbl_base [TBL_DEPTH];
	u64_t tbl_len [TBL_DEPTH];
	logic tbl_avail [TBL_DEPTH];
	u64_t next_frame;
	u64_t kern_lo, kern_hi, boot_lo, boot_hi, rgn_count;

	answer_t pending_answers[$];
	int      errors = 0;
	int      idle_mode = 0;

	function automatic u64_t umin(u64_t x, u64_t y);
		return (x < y) ? x : y;
	endfunction

	function automatic u64_t umax(u64_t x, u64_t y);
		return (x > y) ? x : y;
	endfunction

	// Page indices in [0,n) whose address falls in [lo,hi].
	function automatic page_span_t reserved_span(u64_t base, u64_t lo, u64_t hi, u64_t n);
		page_span_t s = '{64'd0, 64'd0};
		if (lo > hi || hi < base)
			return s;
		if (lo > base)
			s.a = (lo - base) / PG + (((lo - base) % PG) != 0);
		s.b = (hi - base) / PG + 1;
		s.a = umin(s.a, n);
		s.b = umin(s.b, n);
		if (s.a > s.b)
			s.a = s.b;
		return s;
	endfunction

	function automatic u64_t overlap(u64_t a, u64_t b, u64_t m);
		u64_t e = umin(b, m);
		return (e > a) ? e - a : 64'd0;
	endfunction

	function automatic u64_t free_pages_below(page_span_t x, page_span_t y, u64_t m);
		return m - overlap(x.a, x.b, m) - overlap(y.a, y.b, m)
			+ overlap(umax(x.a, y.a), umin(x.b, y.b), m);
	endfunction

	function automatic logic page_free(page_span_t x, page_span_t y, u64_t k);
		return !(k >= x.a && k < x.b) && !(k >= y.a && k < y.b);
	endfunction

	// Address to frame number plus one, or frame number to page address.
	function automatic u64_t walk_regions(u64_t req, logic to_frame);
		u64_t n = umin(rgn_count, TBL_DEPTH);
		u64_t seen = 0;
		u64_t base, len, pages, free_cnt, d, kh, kl, j, lo, hi, mid;
		page_span_t x, y;
		for (int r = 0; r < n; r++) begin
			base = tbl_base[r] & AMASK;
			len = tbl_len[r];
			if (!tbl_avail[r] || len == 0)
				continue;
			pages = umin((len - 1) / PG, (AMASK - base) / PG);
			if (pages == 0)
				continue;
			x = reserved_span(base, kern_lo, kern_hi, pages);
			y = reserved_span(base, boot_lo, boot_hi, pages);
			free_cnt = free_pages_below(x, y, pages);
			if (to_frame) begin
				if ((req & AMASK) >= base) begin
					d = (req & AMASK) - base;
					kh = d / PG;
					// An address on a page boundary belongs to the earlier page first.
					kl = (d % PG == 0 && kh > 0) ? kh - 1 : kh;
					if (kl < pages && page_free(x, y, kl))
						return seen + free_pages_below(x, y, kl) + 1;
					if (kh != kl && kh < pages && page_free(x, y, kh))
						return seen + free_pages_below(x, y, kh) + 1;
				end
			end else if (req - seen < free_cnt) begin
				j = req - seen;
				lo = 0;
				hi = pages - 1;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (free_pages_below(x, y, mid + 1) >= j + 1)
						hi = mid;
					else
						lo = mid + 1;
				end
				return base + lo * PG;
			end
			seen += free_cnt;
			if (!to_frame && req < seen)
				return 0;
		end
		return 0;
	endfunction

	function automatic logic apply_item(stim_row_t it, output answer_t res);
		res = '{'0, 1'b0};
		case (it.op)
			OP_LOAD: begin
				tbl_base[it.idx] = u64_t'(it.base);
				tbl_len[it.idx] = u64_t'(it.len);
				tbl_avail[it.idx] = it.avail;
				return 1'b0;
			end
			OP_A2F: res.ans = addr_t'(walk_regions(u64_t'(it.query), 1'b1));
			OP_F2A: res.ans = addr_t'(walk_regions(u64_t'(it.query), 1'b0));
			default: begin
				if (walk_regions(next_frame, 1'b0) == 0) begin
					res.fail = 1'b1;
				end else begin
					res.ans = addr_t'(next_frame);
					next_frame = (next_frame + 1) & FMASK;
				end
			end
		endcase
		return 1'b1;
	endfunction

	function automatic addr_t rand48();
		return addr_t'({$urandom, $urandom});
	endfunction

	task automatic write_reg(cfg_idx_t idx, addr_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_KERNEL_LO:   kern_lo = u64_t'(value);
			CFG_KERNEL_HI:   kern_hi = u64_t'(value);
			CFG_BOOTINFO_LO: boot_lo = u64_t'(value);
			CFG_BOOTINFO_HI: boot_hi = u64_t'(value);
			default:         rgn_count = u64_t'(value) & 64'h1F;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(stim_row_t it);
		answer_t res;
		@(negedge clk);
		while ((idle_mode == 1 && $urandom_range(99) < 61)
			|| (idle_mode == 3 && $urandom_range(99) < 8)) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.operation <= it.op;
		req_if.entry_index <= it.idx;
		req_if.entry_base <= it.base;
		req_if.entry_length <= it.len;
		req_if.entry_is_available <= it.avail;
		req_if.query_value <= it.query;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		if (apply_item(it, res)) begin
			if (it.typed && (res.ans !== it.ans || res.fail !== it.fail)) begin
				$error("directed row: answer exp %0h got %0h, alloc_failed exp %0b got %0b",
					it.ans, res.ans, it.fail, res.fail);
				errors++;
			end
			pending_answers.push_back(res);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Receiver side: stalls follow the current idle mode.
	always @(negedge clk)
		rsp_if.ready <= !((idle_mode == 2 && $urandom_range(99) < 61)
			|| (idle_mode == 3 && $urandom_range(99) < 8));

	always @(posedge clk) begin
		answer_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected item: answer %0h alloc_failed %0b",
					rsp_if.answer, rsp_if.alloc_failed);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_if.answer !== want.ans) begin
					$error("answer: expected %0h, actual %0h", want.ans, rsp_if.answer);
					errors++;
				end
				if (rsp_if.alloc_failed !== want.fail) begin
					$error("alloc_failed: expected %0b, actual %0b",
						want.fail, rsp_if.alloc_failed);
					errors++;
				end
			end
		end
	end

	function automatic stim_row_t random_item();
		stim_row_t it;
		int pick = $urandom_range(99);
		int s = $urandom_range(TBL_DEPTH - 1);
		u64_t span;
		it = '{OP_A2F, 4'($urandom), rand48(), rand48(), 1'($urandom), rand48(), 1'b0, '0,
			1'b0};
		if (pick < 12) begin
			it.op = OP_LOAD;
			case ($urandom_range(3))
				0: it.base = addr_t'(s * 64'h10_0000
					+ $urandom_range(1) * $urandom_range(32'(PG - 1)));
				1: it.base = addr_t'(AMASK - $urandom_range(20) * PG - $urandom_range(1));
				2: it.base = addr_t'($urandom_range(40) * PG);
				default: ;
			endcase
			case ($urandom_range(5))
				0: it.len = '0;
				1: it.len = addr_t'(AMASK);
				2: ;
				default: it.len = addr_t'($urandom_range(24) * PG
					+ $urandom_range(2) * $urandom_range(4095));
			endcase
			it.avail = ($urandom_range(9) != 0);
		end else if (pick < 50) begin
			it.op = OP_A2F;
			if ($urandom_range(3) != 0) begin
				span = umin(tbl_len[s] + 2 * PG, 30 * PG);
				it.query = addr_t'(tbl_base[s] + $urandom_range(32'(span)));
				if ($urandom_range(2) == 0)
					it.query = it.query & ~addr_t'(PG - 1);
			end
		end else if (pick < 85) begin
			it.op = OP_F2A;
			if ($urandom_range(4) != 0)
				it.query = addr_t'($urandom_range(80));
		end else begin
			it.op = OP_ALLOC;
		end
		return it;
	endfunction

	task automatic set_phase(int ph);
		u64_t b = tbl_base[$urandom_range(TBL_DEPTH - 1)];
		u64_t k0, b0;
		case (ph % 6)
			0: begin
				write_reg(CFG_KERNEL_LO, '0);
				write_reg(CFG_KERNEL_HI, addr_t'(AMASK));
			end
			1: begin
				write_reg(CFG_KERNEL_LO, addr_t'(AMASK));
				write_reg(CFG_KERNEL_HI, '0);
			end
			default: begin
				k0 = b + $urandom_range(6) * PG + $urandom_range(1) * $urandom_range(4095);
				write_reg(CFG_KERNEL_LO, addr_t'(k0));
				write_reg(CFG_KERNEL_HI,
					addr_t'(k0 + $urandom_range(5) * PG + $urandom_range(4095)));
			end
		endcase
		b0 = tbl_base[$urandom_range(TBL_DEPTH - 1)] + $urandom_range(8) * PG;
		if (ph % 5 == 4)
			b0 = u64_t'(rand48());
		write_reg(CFG_BOOTINFO_LO, addr_t'(b0));
		write_reg(CFG_BOOTINFO_HI,
			addr_t'((ph % 4 == 3) ? b0 - 1 : b0 + $urandom_range(3) * PG));
		case (ph % 4)
			0:       write_reg(CFG_REGION_COUNT, addr_t'(TBL_DEPTH));
			1:       write_reg(CFG_REGION_COUNT, addr_t'($urandom_range(31, 17)));
			2:       write_reg(CFG_REGION_COUNT, addr_t'(1));
			default: write_reg(CFG_REGION_COUNT, addr_t'($urandom_range(TBL_DEPTH)));
		endcase
	endtask

	// Rows before the configuration write run with reset settings (no regions).
	stim_row_t directed [] = '{
		'{OP_A2F,   4'd0,  48'h0, 48'h0, 1'b0, 48'h0, 1'b1, 48'h0, 1'b0},
		'{OP_F2A,   4'd0,  48'h0, 48'h0, 1'b0, 48'h0, 1'b1, 48'h0, 1'b0},
		'{OP_ALLOC, 4'd0,  48'h0, 48'h0, 1'b0, 48'h0, 1'b1, 48'h0, 1'b1},
		'{OP_A2F,   4'd0,  48'h0, 48'h0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0, 1'b0},
		'{OP_LOAD,  4'd0,  48'h0, 48'h3001, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd1,  48'h10000, 48'h4000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd2,  48'h20000, 48'h0, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd3,  48'h30000, 48'h1000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd4,  48'h40000, 48'h10000, 1'b0, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd5,  48'hFFFF_FFFF_C000, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0, 1'b0,
			48'h0, 1'b0},
		'{OP_LOAD,  4'd6,  48'h50800, 48'h5000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd7,  48'h70000, 48'h8000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd8,  48'h80000, 48'h2001, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd9,  48'h90000, 48'h6FFF, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd10, 48'hA0000, 48'h9000, 1'b0, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd11, 48'hB0000, 48'h4000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd12, 48'hC0000, 48'h3000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd13, 48'hD0000, 48'h7000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd14, 48'hE0000, 48'h5000, 1'b1, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_LOAD,  4'd15, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0, 1'b0,
			48'h0, 1'b0},
		'{OP_A2F,   4'd0,  48'h0, 48'h0, 1'b0, 48'h11000, 1'b0, 48'h0, 1'b0},
		'{OP_A2F,   4'd0,  48'h0, 48'h0, 1'b0, 48'h10000, 1'b0, 48'h0, 1'b0},
		'{OP_F2A,   4'd0,  48'h0, 48'h0, 1'b0, 48'h0, 1'b0, 48'h0, 1'b0},
		'{OP_F2A,   4'd0,  48'h0, 48'h0, 1'b0, 48'h1, 1'b0, 48'h0, 1'b0},
		'{OP_F2A,   4'd0,  48'h0, 48'h0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0, 1'b0},
		'{OP_ALLOC, 4'd0,  48'h0, 48'h0, 1'b0, 48'h0, 1'b0, 48'h0, 1'b0}
	};

	initial begin
		for (int r = 0; r < TBL_DEPTH; r++) begin
			tbl_base[r] = 0;
			tbl_len[r] = 0;
			tbl_avail[r] = 1'b0;
		end
		next_frame = 1;
		{kern_lo, kern_hi, boot_lo, boot_hi, rgn_count} = '0;
		req_if.valid = 1'b0;
		req_if.operation = OP_LOAD;
		req_if.entry_index = '0;
		req_if.entry_base = '0;
		req_if.entry_length = '0;
		req_if.entry_is_available = 1'b0;
		req_if.query_value = '0;
		rsp_if.ready = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < directed.size(); i++) begin
			// All slots are loaded before any region count lets a lookup read them.
			if (i == 20) begin
				drain();
				write_reg(CFG_KERNEL_LO, 48'h11000);
				write_reg(CFG_KERNEL_HI, 48'h11000);
				write_reg(CFG_BOOTINFO_LO, 48'h71000);
				write_reg(CFG_BOOTINFO_HI, 48'h70FFF);
				write_reg(CFG_REGION_COUNT, addr_t'(TBL_DEPTH));
			end
			send_item(directed[i]);
		end

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			idle_mode = ph % 4;
			set_phase(ph);
			for (int n = 0; n < 150; n++)
				send_item(random_item());
		end
		drain();
		if (pending_answers.size() != 0) begin
			$error("%0d expected items never arrived", pending_answers.size());
			errors++;
		end
		if (errors == 0)
			$display("memory_map_frame_allocator_tb: PASS");
		else
			$display("memory_map_frame_allocator_tb: FAIL");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("memory_map_frame_allocator_tb: FAIL");
		$finish;
	end

endmodule
